@@ src/sdf_pkg.sv @@
// sdf_pkg: shared types and constants for the step/dir position builder.
// Beat payload structs, event and register codes, config struct, core states.
// No dependencies.
`timescale 1ns / 1ps

package sdf_pkg;

  // bit-serial multiplier geometry
  localparam int MAG_W   = 51;                  // multiplicand magnitude
  localparam int GAIN_W  = 32;                  // multiplier (gain) bits
  localparam int Q_SHIFT = 30;                  // Q2.30 gains
  localparam int Q_W     = MAG_W + GAIN_W - Q_SHIFT;
  localparam int CNT_W   = $clog2(GAIN_W);

  // event kinds
  localparam logic [1:0] FUNC_STEP  = 2'd0;
  localparam logic [1:0] FUNC_INDEX = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MULT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_TURN = 3'd5;

  // register reset values
  localparam logic [7:0]  RST_STEP_MULT   = 8'd40;
  localparam logic        RST_FLOW_EN     = 1'b1;
  localparam logic [31:0] RST_LEAD_GAIN   = 32'd1181116006;
  localparam logic [31:0] RST_INPUT_GAIN  = 32'd67968;
  localparam logic [31:0] RST_DECAY_GAIN  = 32'd1073230508;
  localparam logic [15:0] RST_COUNTS_TURN = 16'd2000;

  typedef struct packed {
    logic [1:0]  func;
    logic        direction;
    logic [15:0] encoder_count;
  } evt_t;

  typedef struct packed {
    logic signed [31:0] position_command;
    logic signed [31:0] position_feedback;
    logic signed [15:0] steps_added;
  } res_t;

  typedef struct packed {
    logic [7:0]  step_multiplier;
    logic        flow_comp_enable;
    logic [31:0] lead_gain;
    logic [31:0] filter_input_gain;
    logic [31:0] filter_decay_gain;
    logic [15:0] counts_per_turn;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECENTRE,
    ST_DIFF,
    ST_LEAD,
    ST_LEAD_W,
    ST_ADJ,
    ST_STEPS,
    ST_PSUM,
    ST_IN_W,
    ST_DEC_W,
    ST_MSUM,
    ST_FB,
    ST_FB_W,
    ST_DONE
  } core_state_t;

endpackage

@@ src/sdf_mul.sv @@
// sdf_mul: bit-serial unsigned multiplier, one gain bit per cycle.
// Gives the product shifted right by Q_SHIFT and its low GAIN_W bits.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

module sdf_mul import sdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [GAIN_W-1:0] b,
  output logic              done,
  output logic [Q_W-1:0]    q,
  output logic [GAIN_W-1:0] lo
);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] areg;
  logic [GAIN_W-1:0] breg;
  logic [MAG_W-1:0] acc;
  logic [MAG_W:0]   sum;

  assign sum = {1'b0, acc} + (breg[0] ? {1'b0, areg} : '0);
  assign q   = {acc, lo[GAIN_W-1:Q_SHIFT]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= run && (cnt == CNT_W'(GAIN_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(GAIN_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      acc  <= '0;
    end else if (run) begin
      acc  <= sum[MAG_W:1];
      lo   <= {sum[0], lo[GAIN_W-1:1]};
      breg <= {1'b0, breg[GAIN_W-1:1]};
    end
  end

endmodule

@@ src/sdf_core.sv @@
// sdf_core: position state, event handling and the servo tick sequencer.
// Runs recenter, melt-flow filter and feedback rebuild through sdf_mul.
// Depends on sdf_pkg and sdf_mul.
`timescale 1ns / 1ps

module sdf_core import sdf_pkg::*; #(
  parameter int AXIS_LIMIT = 2000000000,
  parameter int AXIS_SHIFT = 400000000,
  parameter int TURN_SHIFT = 200000
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic start,
  input  evt_t evt,
  output logic idle,
  output logic res_valid,
  input  logic res_take,
  output res_t res
);

  localparam logic signed [31:0] LIM_POS = 32'(AXIS_LIMIT);
  localparam logic signed [31:0] LIM_NEG = -LIM_POS;
  localparam logic [31:0]        AX_SH   = 32'(AXIS_SHIFT);
  localparam logic [31:0]        TN_SH   = 32'(TURN_SHIFT);

  core_state_t state, state_next;

  logic signed [31:0] pend;
  logic [31:0]        turn;
  logic signed [31:0] cmd;
  logic signed [31:0] fb;
  logic signed [47:0] melt;
  logic signed [17:0] rem;
  logic [15:0]        enc;

  logic signed [48:0] diff;
  logic signed [51:0] dx;
  logic signed [52:0] adj;
  logic signed [36:0] steps;
  logic signed [Q_W:0] t1;
  logic signed [Q_W:0] t2;
  logic signed [15:0] sout;
  logic               nsign;

  logic               mul_start;
  logic [MAG_W-1:0]   mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic               mul_done;
  logic [Q_W-1:0]     mul_q;
  logic [GAIN_W-1:0]  mul_lo;

  logic signed [48:0] diff_next;
  logic [48:0]        diff_abs;
  logic [51:0]        dx_abs;
  logic [47:0]        m_abs;
  logic signed [Q_W:0] q_s;
  logic signed [Q_W:0] q_sgn;
  logic signed [52:0] adj_next;
  logic               trunc_fix;
  logic signed [37:0] psum;
  logic signed [32:0] step_sum;
  logic signed [Q_W+1:0] msum;
  logic               neg_hit;
  logic               pos_hit;

  sdf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .q     (mul_q),
    .lo    (mul_lo)
  );

  assign diff_next = {pend[31], pend, 16'b0} - {melt[47], melt};
  assign diff_abs  = diff[48] ? (49'd0 - diff) : diff;
  assign dx_abs    = dx[51] ? (52'd0 - dx) : dx;
  assign m_abs     = melt[47] ? (48'd0 - melt) : melt;
  assign q_s       = {1'b0, mul_q};
  assign q_sgn     = nsign ? -q_s : q_s;
  assign adj_next  = {dx[51], dx} - {{5{pend[31]}}, pend, 16'b0} + {{35{rem[17]}}, rem};
  assign trunc_fix = adj[52] && (adj[15:0] != 16'd0);
  assign psum      = {{6{pend[31]}}, pend} + {steps[36], steps};
  assign msum      = {t1[Q_W], t1} + {t2[Q_W], t2};
  assign step_sum  = evt.direction ? ({pend[31], pend} + {25'b0, cfg.step_multiplier})
                                   : ({pend[31], pend} - {25'b0, cfg.step_multiplier});
  assign neg_hit   = (cmd < LIM_NEG) || (fb < LIM_NEG);
  assign pos_hit   = (cmd > LIM_POS) || (fb > LIM_POS);

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.position_command  = cmd;
  assign res.position_feedback = fb;
  assign res.steps_added       = sout;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start && evt.func == FUNC_TICK) begin
          state_next = ST_RECENTRE;
        end
      end
      ST_RECENTRE: begin
        state_next = cfg.flow_comp_enable ? ST_DIFF : ST_FB;
      end
      ST_DIFF: begin
        state_next = ST_LEAD;
      end
      ST_LEAD: begin
        mul_start  = 1'b1;
        mul_a      = MAG_W'(diff_abs);
        mul_b      = cfg.lead_gain;
        state_next = ST_LEAD_W;
      end
      ST_LEAD_W: begin
        if (mul_done) begin
          state_next = ST_ADJ;
        end
      end
      ST_ADJ: begin
        mul_start  = 1'b1;
        mul_a      = dx_abs[MAG_W-1:0];
        mul_b      = cfg.filter_input_gain;
        state_next = ST_STEPS;
      end
      ST_STEPS: begin
        state_next = ST_PSUM;
      end
      ST_PSUM: begin
        state_next = ST_IN_W;
      end
      ST_IN_W: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = MAG_W'(m_abs);
          mul_b      = cfg.filter_decay_gain;
          state_next = ST_DEC_W;
        end
      end
      ST_DEC_W: begin
        if (mul_done) begin
          state_next = ST_MSUM;
        end
      end
      ST_MSUM: begin
        state_next = ST_FB;
      end
      ST_FB: begin
        mul_start  = 1'b1;
        mul_a      = MAG_W'(turn);
        mul_b      = GAIN_W'(cfg.counts_per_turn);
        state_next = ST_FB_W;
      end
      ST_FB_W: begin
        if (mul_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      turn <= '0;
      cmd  <= '0;
      fb   <= '0;
      melt <= '0;
      rem  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (evt.func)
              FUNC_STEP: begin
                if (step_sum[32] != step_sum[31]) begin
                  pend <= step_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                  pend <= step_sum[31:0];
                end
              end
              FUNC_INDEX: turn <= evt.direction ? turn + 32'd1 : turn - 32'd1;
              default: ;
            endcase
          end
        end
        ST_RECENTRE: begin
          if (neg_hit) begin
            cmd  <= cmd + AX_SH;
            fb   <= fb + AX_SH;
            turn <= turn + TN_SH;
          end else if (pos_hit) begin
            cmd  <= cmd - AX_SH;
            fb   <= fb - AX_SH;
            turn <= turn - TN_SH;
          end
        end
        ST_STEPS: begin
          rem <= trunc_fix ? {2'b11, adj[15:0]} : {2'b00, adj[15:0]};
        end
        ST_PSUM: begin
          if (!((&psum[37:31]) || !(|psum[37:31]))) begin
            pend <= psum[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            pend <= psum[31:0];
          end
        end
        ST_MSUM: begin
          if (!((&msum[Q_W+1:47]) || !(|msum[Q_W+1:47]))) begin
            melt <= msum[Q_W+1] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
          end else begin
            melt <= msum[47:0];
          end
        end
        ST_FB: begin
          cmd  <= cmd + pend;
          pend <= '0;
        end
        ST_FB_W: begin
          if (mul_done) begin
            fb <= mul_lo + {16'b0, enc};
          end
        end
        default: ;
      endcase
    end
  end

  // tick working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        enc <= evt.encoder_count;
      end
      ST_RECENTRE: begin
        steps <= '0;
      end
      ST_DIFF: begin
        diff  <= diff_next;
        nsign <= diff_next[48];
      end
      ST_LEAD_W: begin
        if (mul_done) begin
          dx <= q_sgn[51:0];
        end
      end
      ST_ADJ: begin
        adj   <= adj_next;
        nsign <= dx[51];
      end
      ST_STEPS: begin
        steps <= adj[52:16] + {36'b0, trunc_fix};
      end
      ST_IN_W: begin
        if (mul_done) begin
          t1    <= q_sgn;
          nsign <= melt[47];
        end
      end
      ST_DEC_W: begin
        if (mul_done) begin
          t2 <= q_sgn;
        end
      end
      ST_FB: begin
        if (!((&steps[36:15]) || !(|steps[36:15]))) begin
          sout <= steps[36] ? 16'sh8000 : 16'sh7FFF;
        end else begin
          sout <= steps[15:0];
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/step_dir_position_with_flow_comp.sv @@
// step_dir_position_with_flow_comp: top level, register file, beat handshakes.
// Depends on sdf_pkg and sdf_core.
//
//   channel  signals                         payload  dir
//   evt      evt_valid / evt_ready           evt_t    in
//   res      res_valid / res_ready           res_t    out
//   cfg      cfg_we, cfg_index, cfg_data     32 bit   in
//
// Step and index beats are handled in the idle state and leave the core idle.
// A servo tick runs its products through the bit-serial multiplier: four
// products with flow compensation, one without.
// Reset is synchronous and restores registers and all position state.
// A finished result sits in the output register; a further tick result waits
// in the core until that register is free, and evt_ready stays low meanwhile.
`timescale 1ns / 1ps

module step_dir_position_with_flow_comp import sdf_pkg::*; #(
  parameter int AXIS_LIMIT = 2000000000,
  parameter int AXIS_SHIFT = 400000000,
  parameter int TURN_SHIFT = 200000
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_ready,
  input  evt_t                 evt,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t cfg;
  logic core_idle;
  logic core_res_valid;
  logic core_res_take;
  res_t core_res;

  sdf_core #(
    .AXIS_LIMIT (AXIS_LIMIT),
    .AXIS_SHIFT (AXIS_SHIFT),
    .TURN_SHIFT (TURN_SHIFT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (evt_valid && core_idle),
    .evt       (evt),
    .idle      (core_idle),
    .res_valid (core_res_valid),
    .res_take  (core_res_take),
    .res       (core_res)
  );

  assign evt_ready     = core_idle;
  assign core_res_take = core_res_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_multiplier   <= RST_STEP_MULT;
      cfg.flow_comp_enable  <= RST_FLOW_EN;
      cfg.lead_gain         <= RST_LEAD_GAIN;
      cfg.filter_input_gain <= RST_INPUT_GAIN;
      cfg.filter_decay_gain <= RST_DECAY_GAIN;
      cfg.counts_per_turn   <= RST_COUNTS_TURN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_MULT:   cfg.step_multiplier   <= cfg_data[7:0];
        CFG_FLOW_EN:     cfg.flow_comp_enable  <= cfg_data[0];
        CFG_LEAD_GAIN:   cfg.lead_gain         <= cfg_data;
        CFG_INPUT_GAIN:  cfg.filter_input_gain <= cfg_data;
        CFG_DECAY_GAIN:  cfg.filter_decay_gain <= cfg_data;
        CFG_COUNTS_TURN: cfg.counts_per_turn   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (core_res_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_take) begin
      res <= core_res;
    end
  end

endmodule

@@ tb/pos_tb_pkg.sv @@
// pos_tb_pkg: scoreboard for the step/dir position builder testbench.
// Holds a shadow copy of the registers and position state and the expected tick results.
// Depends on sdf_pkg.
`timescale 1ns / 1ps

package pos_tb_pkg;
  import sdf_pkg::*;

  localparam logic [1:0] FUNC_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam longint AXIS_LIM  = 2000000000;
  localparam logic [31:0] AXIS_STEP = 32'd400000000;
  localparam logic [31:0] TURN_STEP = 32'd200000;
  localparam longint MELT_HI   = 64'sd140737488355327;
  localparam longint MELT_LO   = -MELT_HI - 1;

  class pos_scoreboard;
    cfg_t        regs;
    int          pulses;
    logic [31:0] turns;
    logic [31:0] cmd_pos;
    logic [31:0] fb_pos;
    longint      melt;
    longint      remainder;
    res_t        expected_q[$];
    int          errors;

    function new();
      regs.step_multiplier   = RST_STEP_MULT;
      regs.flow_comp_enable  = RST_FLOW_EN;
      regs.lead_gain         = RST_LEAD_GAIN;
      regs.filter_input_gain = RST_INPUT_GAIN;
      regs.filter_decay_gain = RST_DECAY_GAIN;
      regs.counts_per_turn   = RST_COUNTS_TURN;
      pulses    = 0;
      turns     = '0;
      cmd_pos   = '0;
      fb_pos    = '0;
      melt      = 0;
      remainder = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_STEP_MULT:   regs.step_multiplier   = d[7:0];
        CFG_FLOW_EN:     regs.flow_comp_enable  = d[0];
        CFG_LEAD_GAIN:   regs.lead_gain         = d;
        CFG_INPUT_GAIN:  regs.filter_input_gain = d;
        CFG_DECAY_GAIN:  regs.filter_decay_gain = d;
        CFG_COUNTS_TURN: regs.counts_per_turn   = d[15:0];
        default: ;
      endcase
    endfunction

    // (v * g) >> 30 on the magnitude, sign restored
    function longint scale_q30(longint v, logic [31:0] g);
      logic [63:0] mag;
      logic [95:0] prod;
      longint      r;
      mag  = (v < 0) ? -v : v;
      prod = {32'd0, mag} * {64'd0, g};
      r    = prod[93:30];
      return (v < 0) ? -r : r;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    function void note_event(evt_t e);
      longint mult, c, f, p, p16, dx, adj, nsteps, m;
      res_t   want;
      mult = regs.step_multiplier;
      case (e.func)
        FUNC_STEP: begin
          p = pulses;
          pulses = clamp32(e.direction ? p + mult : p - mult);
        end
        FUNC_INDEX: turns = e.direction ? turns + 32'd1 : turns - 32'd1;
        FUNC_TICK: begin
          c = $signed(cmd_pos);
          f = $signed(fb_pos);
          if (c < -AXIS_LIM || f < -AXIS_LIM) begin
            cmd_pos = cmd_pos + AXIS_STEP;
            fb_pos  = fb_pos + AXIS_STEP;
            turns   = turns + TURN_STEP;
          end else if (c > AXIS_LIM || f > AXIS_LIM) begin
            cmd_pos = cmd_pos - AXIS_STEP;
            fb_pos  = fb_pos - AXIS_STEP;
            turns   = turns - TURN_STEP;
          end
          nsteps = 0;
          if (regs.flow_comp_enable) begin
            p   = pulses;
            p16 = p * 65536;
            dx  = scale_q30(p16 - melt, regs.lead_gain);
            adj = dx - p16 + remainder;
            nsteps    = adj / 65536;
            remainder = adj - nsteps * 65536;
            m = scale_q30(dx, regs.filter_input_gain)
                + scale_q30(melt, regs.filter_decay_gain);
            if (m > MELT_HI) m = MELT_HI;
            if (m < MELT_LO) m = MELT_LO;
            melt   = m;
            pulses = clamp32(p + nsteps);
          end
          cmd_pos = cmd_pos + pulses;
          pulses  = 0;
          fb_pos  = turns * {16'd0, regs.counts_per_turn} + {16'd0, e.encoder_count};
          if (nsteps > 32767) nsteps = 32767;
          if (nsteps < -32768) nsteps = -32768;
          want.position_command  = cmd_pos;
          want.position_feedback = fb_pos;
          want.steps_added       = nsteps[15:0];
          expected_q.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: cmd %0d fb %0d steps %0d", $time,
                 got.position_command, got.position_feedback, got.steps_added);
        return;
      end
      want = expected_q.pop_front();
      if (got.position_command !== want.position_command) begin
        errors++;
        $display("%0t: position_command expected %0d actual %0d", $time,
                 want.position_command, got.position_command);
      end
      if (got.position_feedback !== want.position_feedback) begin
        errors++;
        $display("%0t: position_feedback expected %0d actual %0d", $time,
                 want.position_feedback, got.position_feedback);
      end
      if (got.steps_added !== want.steps_added) begin
        errors++;
        $display("%0t: steps_added expected %0d actual %0d", $time,
                 want.steps_added, got.steps_added);
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
// tb_top: drives step, index and tick beats into step_dir_position_with_flow_comp,
// rewrites its registers between phases and checks every tick result.
// Depends on sdf_pkg, pos_tb_pkg and the RTL under src.
`timescale 1ns / 1ps

module tb_top;
  import sdf_pkg::*;
  import pos_tb_pkg::*;

  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 800;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 205;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid;
  logic evt_ready;
  evt_t evt_beat;
  logic res_valid;
  logic res_ready;
  res_t res_beat;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  pos_scoreboard sb;
  bit tx_no_idle;
  bit rx_no_idle;
  bit hold_req;
  int cycles;

  step_dir_position_with_flow_comp i_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt_beat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_evt(logic [1:0] f, logic dir, logic [15:0] enc);
    int   gap;
    evt_t e;
    e.func = f;
    e.direction = dir;
    e.encoder_count = enc;
    gap = tx_no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_valid <= 1'b1;
    evt_beat  <= e;
    do @(posedge clk); while (!evt_ready);
    sb.note_event(e);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    evt_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_enc();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_config(int ph);
    case (ph)
      0: begin
        write_reg(CFG_STEP_MULT, 32'd255);
        write_reg(CFG_FLOW_EN, 32'd0);
        write_reg(CFG_LEAD_GAIN, 32'd0);
        write_reg(CFG_INPUT_GAIN, 32'd0);
        write_reg(CFG_DECAY_GAIN, 32'd0);
        write_reg(CFG_COUNTS_TURN, 32'd65535);
      end
      1: begin
        // drives the filter and pending pulses into saturation
        write_reg(CFG_STEP_MULT, 32'd0);
        write_reg(CFG_FLOW_EN, 32'd1);
        write_reg(CFG_LEAD_GAIN, 32'hffffffff);
        write_reg(CFG_INPUT_GAIN, 32'hffffffff);
        write_reg(CFG_DECAY_GAIN, 32'hffffffff);
        write_reg(CFG_COUNTS_TURN, 32'd1);
      end
      2: begin
        write_reg(CFG_STEP_MULT, 32'd1);
        write_reg(CFG_LEAD_GAIN, 32'h40000000);
        write_reg(CFG_INPUT_GAIN, 32'h80000000);
        write_reg(CFG_DECAY_GAIN, 32'h20000000);
        write_reg(CFG_COUNTS_TURN, 32'd0);
      end
      3: begin
        write_reg(CFG_STEP_MULT, $urandom | 32'hffffff00);
        write_reg(CFG_FLOW_EN, $urandom | 32'h1);
        write_reg(CFG_LEAD_GAIN, RST_LEAD_GAIN);
        write_reg(CFG_INPUT_GAIN, RST_INPUT_GAIN);
        write_reg(CFG_DECAY_GAIN, RST_DECAY_GAIN);
        write_reg(CFG_COUNTS_TURN, $urandom);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
      end
      default: begin
        write_reg(CFG_STEP_MULT, $urandom);
        write_reg(CFG_FLOW_EN, $urandom);
        write_reg(CFG_LEAD_GAIN, $urandom);
        write_reg(CFG_INPUT_GAIN, $urandom_range(0, 32'h01000000));
        write_reg(CFG_DECAY_GAIN, $urandom);
        write_reg(CFG_COUNTS_TURN, $urandom);
        write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
      end
    endcase
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // step/index bursts closed by a tick, mixed with stray beats
  task automatic run_random(int n_items);
    int         sent;
    int         burst;
    logic [1:0] f;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 15) == 0) tx_no_idle = ~tx_no_idle;
      if ($urandom_range(0, 9) == 0) begin
        f = 2'($urandom_range(0, 3));
        send_evt(f, 1'($urandom), rand_enc());
        if (f != FUNC_RESERVED) sent++;
      end else begin
        burst = $urandom_range(0, 24);
        repeat (burst) begin
          f = ($urandom_range(0, 7) == 0) ? FUNC_INDEX : FUNC_STEP;
          send_evt(f, ($urandom_range(0, 3) != 0), rand_enc());
          sent++;
        end
        send_evt(FUNC_TICK, 1'($urandom), rand_enc());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    evt_valid = 1'b0;
    evt_beat  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    tx_no_idle = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed beats on reset settings
    send_evt(FUNC_TICK, 1'b1, 16'h0000);
    repeat (3) send_evt(FUNC_STEP, 1'b1, 16'h0000);
    send_evt(FUNC_TICK, 1'b0, 16'hffff);
    repeat (5) send_evt(FUNC_STEP, 1'b0, 16'hffff);
    send_evt(FUNC_TICK, 1'b1, 16'h04d2);
    repeat (2) send_evt(FUNC_INDEX, 1'b1, 16'h5555);
    send_evt(FUNC_TICK, 1'b0, 16'h0000);
    repeat (4) send_evt(FUNC_INDEX, 1'b0, 16'haaaa);
    send_evt(FUNC_TICK, 1'b1, 16'hffff);
    send_evt(FUNC_RESERVED, 1'b1, 16'hffff);
    send_evt(FUNC_RESERVED, 1'b0, 16'h0000);
    send_evt(FUNC_TICK, 1'b0, 16'h8000);
    send_evt(FUNC_STEP, 1'b1, 16'h0001);
    send_evt(FUNC_INDEX, 1'b0, 16'h7fff);
    send_evt(FUNC_TICK, 1'b1, 16'h0001);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      set_config(ph);
      if (ph == 2) hold_req = 1'b1;
      run_random(PHASE_ITEMS);
    end

    wait_quiet();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    res_ready  = 1'b0;
    rx_no_idle = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!rx_no_idle) begin
        int gap;
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          res_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res_beat);
      if ($urandom_range(0, 39) == 0) rx_no_idle = ~rx_no_idle;
      @(negedge clk);
    end
  end

endmodule

@@ files.f @@
src/sdf_pkg.sv
src/sdf_mul.sv
src/sdf_core.sv
src/step_dir_position_with_flow_comp.sv
tb/pos_tb_pkg.sv
tb/tb_top.sv
